// ===== hw/rtl/wmt_pkg.sv =====
// ----------------------------------------------------------------------------
// wmt_pkg
// shared types, register and mode codes, and q16.48 arithmetic helpers
// ----------------------------------------------------------------------------
`default_nettype none

package wmt_pkg;

  localparam int CFG_AW = 6;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_SIZE_X      = 3'd0;
  localparam logic [2:0] REG_SIZE_Y      = 3'd1;
  localparam logic [2:0] REG_SIZE_Z      = 3'd2;
  localparam logic [2:0] REG_ACTIVE_AXES = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;
  localparam logic [2:0] REG_HM_COEF     = 3'd5;

  // request modes
  localparam logic [1:0] MODE_LOAD_CELL  = 2'd0;
  localparam logic [1:0] MODE_LOAD_WIDTH = 2'd1;
  localparam logic [1:0] MODE_READ       = 2'd2;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sval_t;

  function automatic logic [63:0] mag_of(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // floor((a+b)/2) without overflow
  function automatic logic [63:0] favg(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    t = a ^ b;
    return (a & b) + {t[63], t[63:1]};
  endfunction

  function automatic sval_t ssub(input logic [63:0] a, input logic [63:0] b);
    sval_t       s;
    logic [63:0] r;
    r = a - b;
    s.sat = (a[63] ^ b[63]) & (a[63] ^ r[63]);
    s.val = s.sat ? (a[63] ? SMIN : SMAX) : r;
    return s;
  endfunction

  // sign and magnitude back to two's complement with saturation
  function automatic sval_t pack_q(input logic [63:0] mag, input logic neg, input logic over);
    sval_t s;
    if (!neg) begin
      s.sat = over || (mag > SMAX);
      s.val = s.sat ? SMAX : mag;
    end else begin
      s.sat = over || (mag > SMIN);
      s.val = s.sat ? SMIN : (64'd0 - mag);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wmt_if.sv =====
// ----------------------------------------------------------------------------
// wmt request and response channels
// valid/ready channels carrying the request and response payloads
// ----------------------------------------------------------------------------
`default_nettype none

interface wmt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [4:0]         pos_x;
  logic [4:0]         pos_y;
  logic [4:0]         pos_z;
  logic signed [63:0] density;
  logic signed [63:0] psi_real;
  logic signed [63:0] psi_imag;
  logic [62:0]        width_x;
  logic [62:0]        width_y;
  logic [62:0]        width_z;

  modport source (output valid, mode, pos_x, pos_y, pos_z, density, psi_real, psi_imag,
                  width_x, width_y, width_z, input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, density, psi_real, psi_imag,
                width_x, width_y, width_z, output ready);
endinterface

interface wmt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] new_density;
  logic               saturated;

  modport source (output valid, new_density, saturated, input ready);
  modport sink (input valid, new_density, saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wavefunction_mass_transport.sv =====
// ----------------------------------------------------------------------------
// wavefunction_mass_transport
// density update from the probability current of a stored complex field
// ----------------------------------------------------------------------------
// usage:
//   req carries one request per handshake. mode load-cell writes density and
//   the wavefunction of one cell, mode load-width writes one width entry per
//   axis, mode read returns the cell density after one transport step.
//   loads give no response; a read outside the grid and
//   the unused mode are dropped.
//   rsp carries one response per read: new_density and the saturated flag.
//   a read walks the cell memory (cell plus up to two neighbors per axis)
//   and the width memories, then runs each face through a shared multiplier
//   (one 32x32 partial product per cycle) and a shared bit-serial divider
//   (one quotient bit per cycle). at an upper boundary an axis has zero flux
//   difference and skips the face terms, but still runs the divide by width.
//   one request is worked at a time; req.ready is high only when idle.
//   the response sits in an output register; the block may take new loads
//   while it waits, and a finished read holds until rsp drains.
//   reset (rst, synchronous) returns config registers to their defaults and
//   clears control state; memory contents are undefined until written.
//   the config port is apb-style, 64-bit data, register i at byte 8*i.
// ----------------------------------------------------------------------------
`default_nettype none

module wavefunction_mass_transport #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  wmt_req_if.sink                    req,
  wmt_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wmt_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import wmt_pkg::*;

  localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

  localparam logic [AW-1:0] STRIDE_X = AW'(1);
  localparam logic [AW-1:0] STRIDE_Y = AW'(MAX_X);
  localparam logic [AW-1:0] STRIDE_Z = AW'(MAX_X * MAX_Y);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDC0 = 5'd1;   // cell read issued
  localparam logic [4:0] S_RDC1 = 5'd2;   // cell data back
  localparam logic [4:0] S_AX0  = 5'd3;   // width at p issued
  localparam logic [4:0] S_AX1  = 5'd4;   // width at p back, p+1 issued
  localparam logic [4:0] S_AX2  = 5'd5;   // width at p+1 back
  localparam logic [4:0] S_RDN0 = 5'd6;   // neighbor read issued
  localparam logic [4:0] S_RDN1 = 5'd7;   // neighbor data back
  localparam logic [4:0] S_M1   = 5'd8;   // avg(re) * d(im)
  localparam logic [4:0] S_M2   = 5'd9;   // avg(im) * d(re)
  localparam logic [4:0] S_DIVF = 5'd10;  // face term / width
  localparam logic [4:0] S_M3   = 5'd11;  // * hm_coef
  localparam logic [4:0] S_FD   = 5'd12;  // flux difference
  localparam logic [4:0] S_DIVR = 5'd13;  // flux difference / width
  localparam logic [4:0] S_MT   = 5'd14;  // * time_step
  localparam logic [4:0] S_UPD  = 5'd15;  // density update
  localparam logic [4:0] S_OUT  = 5'd16;  // hand to output register

  // config registers
  logic [5:0]  size_x;
  logic [5:0]  size_y;
  logic [5:0]  size_z;
  logic [1:0]  active_axes;
  logic [63:0] time_step;
  logic [63:0] hm_coef;

  logic [4:0]    state;
  logic          op_busy;
  logic [1:0]    axis;
  logic          face_lo;     // working on the lower face of the cell
  logic [4:0]    px;
  logic [4:0]    py;
  logic [4:0]    pz;
  logic [AW-1:0] c;

  // datapath registers
  logic [63:0] d;
  logic        sat;
  logic [63:0] re_c;
  logic [63:0] im_c;
  logic [63:0] re_n;
  logic [63:0] im_n;
  logic [62:0] w_c;
  logic [62:0] w_u;
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] qv;
  logic [63:0] up;
  logic [63:0] here;
  logic [63:0] fd;
  logic        rsp_valid;

  logic          acc_in;
  logic          inside_in;
  logic [AW-1:0] c_in;
  logic [31:0]   tx;
  logic [31:0]   ty;
  logic [31:0]   tz;
  logic [31:0]   rx;
  logic [31:0]   ry;
  logic [31:0]   rz;
  logic          cell_we;
  logic [AW-1:0] cell_raddr;
  logic [191:0]  cell_rdata;
  logic [62:0]   wx_rdata;
  logic [62:0]   wy_rdata;
  logic [62:0]   wz_rdata;
  logic [62:0]   w_rd;
  logic          wx_we;
  logic          wy_we;
  logic          wz_we;

  logic [8:0]    n_x;
  logic [8:0]    n_y;
  logic [8:0]    n_z;
  logic [8:0]    cur_n;
  logic [4:0]    cur_p;
  logic [AW-1:0] cur_stride;
  logic          has_up;
  logic [1:0]    last_axis;

  logic [63:0] fa_re;
  logic [63:0] fa_im;
  logic [63:0] fb_re;
  logic [63:0] fb_im;
  logic [62:0] fw;
  sval_t       pre_sub;
  sval_t       fd_sub;
  sval_t       upd_sub;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  sval_t       mul_res;
  logic        div_start;
  logic [63:0] div_a;
  logic [62:0] div_w;
  logic        div_done;
  sval_t       div_res;

  // size 0 acts as 1, sizes above the axis maximum clamp
  function automatic logic [8:0] eff_size(input logic [5:0] v, input int mx);
    logic [8:0] v9;
    v9 = {3'd0, v};
    if (v == 6'd0) begin
      return 9'd1;
    end else if (v9 > 9'(mx)) begin
      return 9'(mx);
    end
    return v9;
  endfunction

  // ---------------- config port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= 6'd32;
      size_y      <= 6'd32;
      size_z      <= 6'd32;
      active_axes <= 2'd3;
      time_step   <= '0;
      hm_coef     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_SIZE_X:      size_x      <= pwdata[5:0];
        REG_SIZE_Y:      size_y      <= pwdata[5:0];
        REG_SIZE_Z:      size_z      <= pwdata[5:0];
        REG_ACTIVE_AXES: active_axes <= pwdata[1:0];
        REG_TIME_STEP:   time_step   <= pwdata;
        REG_HM_COEF:     hm_coef     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_SIZE_X:      prdata = {58'd0, size_x};
      REG_SIZE_Y:      prdata = {58'd0, size_y};
      REG_SIZE_Z:      prdata = {58'd0, size_z};
      REG_ACTIVE_AXES: prdata = {62'd0, active_axes};
      REG_TIME_STEP:   prdata = time_step;
      REG_HM_COEF:     prdata = hm_coef;
      default:         prdata = '0;
    endcase
  end

  // ---------------- request decode ----------------
  assign req.ready = (state == S_IDLE);
  assign acc_in    = req.valid && req.ready;

  always_comb begin
    tx        = 32'(req.pos_x);
    ty        = 32'(req.pos_y);
    tz        = 32'(req.pos_z);
    inside_in = (tx < 32'(MAX_X)) && (ty < 32'(MAX_Y)) && (tz < 32'(MAX_Z));
    // cell index = (z * MAX_Y + y) * MAX_X + x
    c_in      = AW'((tz * 32'(MAX_Y) + ty) * 32'(MAX_X) + tx);
    cell_we   = acc_in && (req.mode == MODE_LOAD_CELL) && inside_in;
    wx_we     = acc_in && (req.mode == MODE_LOAD_WIDTH) && (tx < 32'(MAX_X));
    wy_we     = acc_in && (req.mode == MODE_LOAD_WIDTH) && (ty < 32'(MAX_Y));
    wz_we     = acc_in && (req.mode == MODE_LOAD_WIDTH) && (tz < 32'(MAX_Z));
    // width reads: entry p in S_AX0, entry p+1 in S_AX1
    rx        = 32'(px) + ((state == S_AX1) ? 32'd1 : 32'd0);
    ry        = 32'(py) + ((state == S_AX1) ? 32'd1 : 32'd0);
    rz        = 32'(pz) + ((state == S_AX1) ? 32'd1 : 32'd0);
  end

  // ---------------- axis selection ----------------
  always_comb begin
    n_x = eff_size(size_x, MAX_X);
    n_y = eff_size(size_y, MAX_Y);
    n_z = eff_size(size_z, MAX_Z);
    unique case (axis)
      AXIS_Y: begin
        cur_n = n_y; cur_p = py; cur_stride = STRIDE_Y; w_rd = wy_rdata;
      end
      AXIS_Z: begin
        cur_n = n_z; cur_p = pz; cur_stride = STRIDE_Z; w_rd = wz_rdata;
      end
      default: begin
        cur_n = n_x; cur_p = px; cur_stride = STRIDE_X; w_rd = wx_rdata;
      end
    endcase
    has_up = ({4'd0, cur_p} + 9'd1) < cur_n;
    // zero axes acts as x only
    if (active_axes == 2'd3) begin
      last_axis = AXIS_Z;
    end else if (active_axes == 2'd2) begin
      last_axis = AXIS_Y;
    end else begin
      last_axis = AXIS_X;
    end
  end

  // ---------------- memories ----------------
  always_comb begin
    if (state == S_RDN0) begin
      cell_raddr = face_lo ? (c - cur_stride) : (c + cur_stride);
    end else begin
      cell_raddr = c;
    end
  end

  // word layout: density, real part, imaginary part
  wmt_ram #(.W(192), .DEPTH(CELLS)) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(c_in),
    .wdata({req.density, req.psi_real, req.psi_imag}),
    .raddr(cell_raddr),
    .rdata(cell_rdata)
  );

  wmt_ram #(.W(63), .DEPTH(MAX_X)) u_wx_ram (
    .clk  (clk),
    .we   (wx_we),
    .waddr(tx[XW-1:0]),
    .wdata(req.width_x),
    .raddr(rx[XW-1:0]),
    .rdata(wx_rdata)
  );

  wmt_ram #(.W(63), .DEPTH(MAX_Y)) u_wy_ram (
    .clk  (clk),
    .we   (wy_we),
    .waddr(ty[YW-1:0]),
    .wdata(req.width_y),
    .raddr(ry[YW-1:0]),
    .rdata(wy_rdata)
  );

  wmt_ram #(.W(63), .DEPTH(MAX_Z)) u_wz_ram (
    .clk  (clk),
    .we   (wz_we),
    .waddr(tz[ZW-1:0]),
    .wdata(req.width_z),
    .raddr(rz[ZW-1:0]),
    .rdata(wz_rdata)
  );

  // ---------------- operand selection ----------------
  // upper face: a = neighbor above, b = this cell, width of cell above
  // lower face: a = this cell, b = neighbor below, width of this cell
  always_comb begin
    fa_re = face_lo ? re_c : re_n;
    fa_im = face_lo ? im_c : im_n;
    fb_re = face_lo ? re_n : re_c;
    fb_im = face_lo ? im_n : im_c;
    fw    = face_lo ? w_c : w_u;

    case (state)
      S_M1:    pre_sub = ssub(fa_im, fb_im);
      S_M2:    pre_sub = ssub(fa_re, fb_re);
      default: pre_sub = ssub(t1, t2);
    endcase
    fd_sub  = ssub(up, here);
    upd_sub = ssub(d, t1);

    case (state)
      S_M1: begin
        mul_a = favg(fa_re, fb_re); mul_b = pre_sub.val;
      end
      S_M2: begin
        mul_a = favg(fa_im, fb_im); mul_b = pre_sub.val;
      end
      S_M3: begin
        mul_a = qv; mul_b = hm_coef;
      end
      default: begin
        mul_a = qv; mul_b = time_step;
      end
    endcase
    mul_start = !op_busy &&
                ((state == S_M1) || (state == S_M2) || (state == S_M3) || (state == S_MT));

    if (state == S_DIVF) begin
      div_a = pre_sub.val; div_w = fw;
    end else begin
      div_a = fd; div_w = w_c;
    end
    div_start = !op_busy && ((state == S_DIVF) || (state == S_DIVR));
  end

  wmt_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  wmt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .a    (div_a),
    .w    (div_w),
    .done (div_done),
    .res  (div_res)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op_busy <= 1'b0;
      axis    <= AXIS_X;
      face_lo <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc_in && (req.mode == MODE_READ) && inside_in) begin
            px    <= req.pos_x;
            py    <= req.pos_y;
            pz    <= req.pos_z;
            c     <= c_in;
            state <= S_RDC0;
          end
        end
        S_RDC0: state <= S_RDC1;
        S_RDC1: begin
          d     <= cell_rdata[191:128];
          re_c  <= cell_rdata[127:64];
          im_c  <= cell_rdata[63:0];
          sat   <= 1'b0;
          axis  <= AXIS_X;
          state <= S_AX0;
        end
        S_AX0: state <= S_AX1;
        S_AX1: begin
          w_c   <= w_rd;
          state <= S_AX2;
        end
        S_AX2: begin
          w_u     <= w_rd;
          face_lo <= 1'b0;
          if (has_up) begin
            state <= S_RDN0;
          end else begin
            // upper boundary: no flux difference
            fd    <= '0;
            state <= S_DIVR;
          end
        end
        S_RDN0: state <= S_RDN1;
        S_RDN1: begin
          re_n  <= cell_rdata[127:64];
          im_n  <= cell_rdata[63:0];
          state <= S_M1;
        end
        S_M1: begin
          if (!op_busy) begin
            op_busy <= 1'b1;
            sat     <= sat | pre_sub.sat;
          end else if (mul_done) begin
            op_busy <= 1'b0;
            t1      <= mul_res.val;
            sat     <= sat | mul_res.sat;
            state   <= S_M2;
          end
        end
        S_M2: begin
          if (!op_busy) begin
            op_busy <= 1'b1;
            sat     <= sat | pre_sub.sat;
          end else if (mul_done) begin
            op_busy <= 1'b0;
            t2      <= mul_res.val;
            sat     <= sat | mul_res.sat;
            state   <= S_DIVF;
          end
        end
        S_DIVF: begin
          if (!op_busy) begin
            op_busy <= 1'b1;
            sat     <= sat | pre_sub.sat;
          end else if (div_done) begin
            op_busy <= 1'b0;
            qv      <= div_res.val;
            sat     <= sat | div_res.sat;
            state   <= S_M3;
          end
        end
        S_M3: begin
          if (!op_busy) begin
            op_busy <= 1'b1;
          end else if (mul_done) begin
            op_busy <= 1'b0;
            sat     <= sat | mul_res.sat;
            if (face_lo) begin
              here  <= mul_res.val;
              state <= S_FD;
            end else begin
              up <= mul_res.val;
              if (cur_p != 5'd0) begin
                face_lo <= 1'b1;
                state   <= S_RDN0;
              end else begin
                // lower boundary: zero momentum
                here  <= '0;
                state <= S_FD;
              end
            end
          end
        end
        S_FD: begin
          fd    <= fd_sub.val;
          sat   <= sat | fd_sub.sat;
          state <= S_DIVR;
        end
        S_DIVR: begin
          if (!op_busy) begin
            op_busy <= 1'b1;
          end else if (div_done) begin
            op_busy <= 1'b0;
            qv      <= div_res.val;
            sat     <= sat | div_res.sat;
            state   <= S_MT;
          end
        end
        S_MT: begin
          if (!op_busy) begin
            op_busy <= 1'b1;
          end else if (mul_done) begin
            op_busy <= 1'b0;
            t1      <= mul_res.val;
            sat     <= sat | mul_res.sat;
            state   <= S_UPD;
          end
        end
        S_UPD: begin
          d   <= upd_sub.val;
          sat <= sat | upd_sub.sat;
          if (axis == last_axis) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_AX0;
          end
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_OUT) && (!rsp_valid || rsp.ready)) begin
      rsp_valid       <= 1'b1;
      rsp.new_density <= d;
      rsp.saturated   <= sat;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/wmt_ram.sv =====
// ----------------------------------------------------------------------------
// wmt_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module wmt_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wmt_mul.sv =====
// ----------------------------------------------------------------------------
// wmt_mul
// q16.48 multiply, one 32x32 partial product per cycle, saturated result
// ----------------------------------------------------------------------------
`default_nettype none

module wmt_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output wmt_pkg::sval_t res
);
  import wmt_pkg::*;

  logic [63:0]  x;
  logic [63:0]  y;
  logic         neg;
  logic         run;
  logic [2:0]   k;
  logic [127:0] acc;
  logic [127:0] pp_sh;
  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [63:0]  pp;
  logic [63:0]  m;

  always_comb begin
    xs = k[1] ? x[63:32] : x[31:0];
    ys = k[0] ? y[63:32] : y[31:0];
    pp = xs * ys;
    case (k[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    m = acc[111:48];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x   <= mag_of(a);
        y   <= mag_of(b);
        neg <= a[63] ^ b[63];
        acc <= '0;
        k   <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (k[2]) begin
          res  <= pack_q(m, neg && (m != 64'd0), |acc[127:112]);
          done <= 1'b1;
          run  <= 1'b0;
        end else begin
          acc <= acc + pp_sh;
          k   <= k + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wmt_div.sv =====
// ----------------------------------------------------------------------------
// wmt_div
// q16.48 divide by an unsigned width, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wmt_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [62:0]   w,
  output logic          done,
  output wmt_pkg::sval_t res
);
  import wmt_pkg::*;

  logic [63:0] ma;
  logic [63:0] r;
  logic [63:0] rs;
  logic [63:0] lo;
  logic [63:0] q;
  logic [62:0] wd;
  logic [6:0]  cnt;
  logic        neg;
  logic        run;
  logic        ge;

  always_comb begin
    ma = mag_of(a);
    rs = {r[62:0], lo[63]};
    ge = rs >= {1'b0, wd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= a[63];
        wd  <= w;
        if (w == 63'd0) begin
          // zero width
          res.sat <= 1'b1;
          res.val <= (a == 64'd0) ? 64'd0 : (a[63] ? SMIN : SMAX);
          done    <= 1'b1;
        end else if (ma == 64'd0) begin
          res  <= '0;
          done <= 1'b1;
        end else if ({15'd0, ma[63:16]} >= w) begin
          res  <= pack_q(64'd0, a[63], 1'b1);
          done <= 1'b1;
        end else begin
          r   <= {16'd0, ma[63:16]};
          lo  <= {ma[15:0], 48'd0};
          q   <= '0;
          cnt <= '0;
          run <= 1'b1;
        end
      end else if (run) begin
        if (cnt[6]) begin
          res  <= pack_q(q, neg && (q != 64'd0), 1'b0);
          done <= 1'b1;
          run  <= 1'b0;
        end else begin
          r   <= ge ? (rs - {1'b0, wd}) : rs;
          q   <= {q[62:0], ge};
          lo  <= {lo[62:0], 1'b0};
          cnt <= cnt + 7'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wmt_checker.sv =====
// ----------------------------------------------------------------------------
// wmt_checker
// port-level checks on the request and response channels
// ----------------------------------------------------------------------------
`default_nettype none

module wmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_mode,
  input logic       rsp_valid,
  input logic       rsp_ready
);
  import wmt_pkg::*;

  // no response survives reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a pending response is not withdrawn
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // a load request leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_mode == MODE_LOAD_CELL || req_mode == MODE_LOAD_WIDTH)
    |=> req_ready)
    else $error("load request blocked the next request");

endmodule

bind wavefunction_mass_transport wmt_checker u_wmt_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .req_mode (req.mode),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready)
);

`default_nettype wire

// ===== test/wavefunction_mass_transport_tb.sv =====
// ----------------------------------------------------------------------------
// wavefunction_mass_transport testbench
// drives load and read requests under several register settings, predicts
// every updated density with an independent fixed-point model of the
// transport step and checks each response in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wavefunction_mass_transport_tb;
  import wmt_pkg::*;

  localparam int           WATCHDOG_LIMIT = 20000;
  localparam int           HOLD_CYCLES    = 3000;
  localparam int           SETTLE_CYCLES  = 1000;
  localparam logic [1:0]   MODE_UNUSED    = 2'd3;
  localparam logic [63:0]  Q_ONE          = 64'h0001_0000_0000_0000;
  localparam logic [62:0]  W_MAX          = 63'h7FFF_FFFF_FFFF_FFFF;

  // one request as the predictor and the driver see it
  typedef struct {
    logic [1:0]  mode;
    logic [4:0]  px, py, pz;
    logic [63:0] dens, re, im;
    logic [62:0] wx, wy, wz;
  } req_t;

  typedef struct {
    logic [63:0] nd;
    logic        sat;
  } density_t;

  // --------------------------------------------------------------------------
  // transport predictor and in-order response checker
  // --------------------------------------------------------------------------
  class density_scoreboard;
    logic [63:0] dens_mem [32768];
    logic [63:0] re_mem   [32768];
    logic [63:0] im_mem   [32768];
    logic [63:0] wtab     [3][32];
    int          size_cfg [3];
    int          axes_cfg;
    logic [63:0] dt, hm;
    bit          ovf;
    density_t    want [$];
    int          errors;

    function new();
      size_cfg = '{32, 32, 32};
      axes_cfg = 3;
      dt       = '0;
      hm       = '0;
      errors   = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [63:0] v);
      case (idx)
        REG_SIZE_X:      size_cfg[0] = v[5:0];
        REG_SIZE_Y:      size_cfg[1] = v[5:0];
        REG_SIZE_Z:      size_cfg[2] = v[5:0];
        REG_ACTIVE_AXES: axes_cfg = v[1:0];
        REG_TIME_STEP:   dt = v;
        REG_HM_COEF:     hm = v;
        default: ;
      endcase
    endfunction

    function int eff(input int v);
      if (v == 0) return 1;
      return (v > 32) ? 32 : v;
    endfunction

    function logic [63:0] half_sum(input logic [63:0] a, input logic [63:0] b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      s = s >>> 1;
      return s[63:0];
    endfunction

    function logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic signed [64:0] r;
      r = $signed({a[63], a}) - $signed({b[63], b});
      if (r[64] != r[63]) begin
        ovf = 1'b1;
        return a[63] ? SMIN : SMAX;
      end
      return r[63:0];
    endfunction

    function logic [63:0] clamp(input logic [127:0] mag, input bit neg);
      if (!neg) begin
        if (mag > 128'(SMAX)) begin
          ovf = 1'b1;
          return SMAX;
        end
        return mag[63:0];
      end
      if (mag > 128'(SMIN)) begin
        ovf = 1'b1;
        return SMIN;
      end
      return 64'd0 - mag[63:0];
    endfunction

    function logic [63:0] abs64(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
    endfunction

    // the sign is dropped when the kept 64 product bits are all zero
    function logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(abs64(a)) * 128'(abs64(b));
      p = p >> 48;
      return clamp(p, (a[63] ^ b[63]) && (p[63:0] != 64'd0));
    endfunction

    function logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] w);
      logic [63:0] m;
      if (w == 0) begin
        ovf = 1'b1;
        if (a == 0) return '0;
        return a[63] ? SMIN : SMAX;
      end
      m = abs64(a);
      if (m == 0) return '0;
      return clamp({16'd0, m, 48'd0} / 128'(w), a[63]);
    endfunction

    // momentum on the face between cell c and its lower neighbor nb
    function logic [63:0] face_mom(input int c, input int nb, input logic [63:0] w);
      logic [63:0] t1, t2;
      t1 = fx_mul(half_sum(re_mem[c], re_mem[nb]), sat_sub(im_mem[c], im_mem[nb]));
      t2 = fx_mul(half_sum(im_mem[c], im_mem[nb]), sat_sub(re_mem[c], re_mem[nb]));
      return fx_mul(fx_div(sat_sub(t1, t2), w), hm);
    endfunction

    function logic [63:0] axis_step(input logic [63:0] d, input int c, input int stride,
                                    input int a, input int p);
      logic [63:0] fd, up, here;
      fd = '0;
      if (p + 1 < eff(size_cfg[a])) begin
        up   = face_mom(c + stride, c, wtab[a][p + 1]);
        here = (p == 0) ? 64'd0 : face_mom(c, c - stride, wtab[a][p]);
        fd   = sat_sub(up, here);
      end
      return sat_sub(d, fx_mul(fx_div(fd, wtab[a][p]), dt));
    endfunction

    function void note_request(input req_t it);
      int          c;
      logic [63:0] d;
      density_t    r;
      c = int'(it.pz) * 1024 + int'(it.py) * 32 + int'(it.px);
      case (it.mode)
        MODE_LOAD_CELL: begin
          dens_mem[c] = it.dens;
          re_mem[c]   = it.re;
          im_mem[c]   = it.im;
        end
        MODE_LOAD_WIDTH: begin
          wtab[0][it.px] = {1'b0, it.wx};
          wtab[1][it.py] = {1'b0, it.wy};
          wtab[2][it.pz] = {1'b0, it.wz};
        end
        MODE_READ: begin
          ovf = 1'b0;
          d   = axis_step(dens_mem[c], c, 1, 0, it.px);
          if (axes_cfg > 1) d = axis_step(d, c, 32, 1, it.py);
          if (axes_cfg > 2) d = axis_step(d, c, 1024, 2, it.pz);
          r.nd  = d;
          r.sat = ovf;
          want.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_response(input logic [63:0] nd, input logic sat);
      density_t e;
      if (want.size() == 0) begin
        $error("response with no read outstanding: new_density %h", nd);
        errors++;
        return;
      end
      e = want.pop_front();
      if (nd !== e.nd) begin
        $error("new_density expected %h actual %h", e.nd, nd);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %b actual %b", e.sat, sat);
        errors++;
      end
    endfunction

    function int outstanding();
      return want.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, block and channels
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;

  wmt_req_if req_ch ();
  wmt_rsp_if rsp_ch ();

  always #10 clk = ~clk;

  wavefunction_mass_transport DUT (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  density_scoreboard scoreboard = new();

  // stimulus-side view of which entries hold data, so no read ever touches
  // an entry that was never loaded
  bit cell_set [32768];
  bit wset     [3][32];
  int sz       [3];
  int axes_eff;
  bit calm;      // no idling on either side in this phase
  bit hold_rsp;  // ask the response side for one long hold-off
  int sent_items;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_q();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = SMAX;
          1: v = SMIN;
          2: v = '0;
          3: v = 64'd1;
          default: v = '1;
        endcase
      end
      1: v = {$urandom, $urandom};
      default: begin
        v = {$urandom, $urandom};
        v = $signed(v) >>> $urandom_range(6, 18);
      end
    endcase
    return v;
  endfunction

  function automatic logic [62:0] rand_w();
    logic [63:0] v;
    case ($urandom_range(0, 11))
      0: return '0;
      1: return W_MAX;
      2: return 63'd1;
      3: begin
        v = {$urandom, $urandom};
        return v[62:0];
      end
      default: begin
        // widths near one cell unit keep the arithmetic out of saturation
        v = {$urandom, $urandom} >> $urandom_range(14, 18);
        return v[62:0];
      end
    endcase
  endfunction

  function automatic req_t rand_req(input logic [1:0] mode);
    req_t it;
    it.mode = mode;
    it.px   = 5'($urandom);
    it.py   = 5'($urandom);
    it.pz   = 5'($urandom);
    it.dens = rand_q();
    it.re   = rand_q();
    it.im   = rand_q();
    it.wx   = rand_w();
    it.wy   = rand_w();
    it.wz   = rand_w();
    return it;
  endfunction

  // position along one axis, mostly inside the region in use or one past it
  function automatic int pick_pos(input int a);
    int lim;
    lim = (sz[a] > 31) ? 31 : sz[a];
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, lim);
    return $urandom_range(0, 31);
  endfunction

  function automatic int cell_of(input int x, input int y, input int z);
    return z * 1024 + y * 32 + x;
  endfunction

  // read of (x,y,z), or the load that one of its inputs still lacks
  function automatic req_t read_or_fill(input int x, input int y, input int z);
    req_t it;
    int   p [3];
    int   q [3];
    p = '{x, y, z};
    if (!cell_set[cell_of(x, y, z)]) begin
      it = rand_req(MODE_LOAD_CELL);
      {it.px, it.py, it.pz} = {5'(x), 5'(y), 5'(z)};
      return it;
    end
    for (int a = 0; a < axes_eff; a++) begin
      for (int k = 0; k < 3; k++) begin
        // k: own width, upper neighbor, lower neighbor
        if (k > 0 && p[a] + 1 >= sz[a]) break;
        q = p;
        if (k == 0 && !wset[a][p[a]]) begin
          it = rand_req(MODE_LOAD_WIDTH);
          case (a)
            0: it.px = 5'(p[a]);
            1: it.py = 5'(p[a]);
            default: it.pz = 5'(p[a]);
          endcase
          return it;
        end
        if (k == 1 && !wset[a][p[a] + 1]) begin
          it = rand_req(MODE_LOAD_WIDTH);
          case (a)
            0: it.px = 5'(p[a] + 1);
            1: it.py = 5'(p[a] + 1);
            default: it.pz = 5'(p[a] + 1);
          endcase
          return it;
        end
        if (k == 1) q[a] = p[a] + 1;
        if (k == 2) begin
          if (p[a] == 0) continue;
          q[a] = p[a] - 1;
        end
        if (k > 0 && !cell_set[cell_of(q[0], q[1], q[2])]) begin
          it = rand_req(MODE_LOAD_CELL);
          {it.px, it.py, it.pz} = {5'(q[0]), 5'(q[1]), 5'(q[2])};
          return it;
        end
      end
    end
    it = rand_req(MODE_READ);
    {it.px, it.py, it.pz} = {5'(x), 5'(y), 5'(z)};
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  task automatic send(input req_t it);
    int gap;
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= it.mode;
    req_ch.pos_x    <= it.px;
    req_ch.pos_y    <= it.py;
    req_ch.pos_z    <= it.pz;
    req_ch.density  <= it.dens;
    req_ch.psi_real <= it.re;
    req_ch.psi_imag <= it.im;
    req_ch.width_x  <= it.wx;
    req_ch.width_y  <= it.wy;
    req_ch.width_z  <= it.wz;
    do @(posedge clk); while (!req_ch.ready);
    scoreboard.note_request(it);
    sent_items++;
    if (it.mode == MODE_LOAD_CELL) cell_set[cell_of(it.px, it.py, it.pz)] = 1'b1;
    if (it.mode == MODE_LOAD_WIDTH) begin
      wset[0][it.px] = 1'b1;
      wset[1][it.py] = 1'b1;
      wset[2][it.pz] = 1'b1;
    end
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // keeps sending fill loads until the read itself goes out
  task automatic issue_read(input int x, input int y, input int z);
    req_t it;
    do begin
      it = read_or_fill(x, y, z);
      send(it);
    end while (it.mode != MODE_READ);
  endtask

  task automatic load_cell(input int x, input int y, input int z,
                           input logic [63:0] d, input logic [63:0] re, input logic [63:0] im);
    req_t it;
    it = rand_req(MODE_LOAD_CELL);
    {it.px, it.py, it.pz} = {5'(x), 5'(y), 5'(z)};
    {it.dens, it.re, it.im} = {d, re, im};
    send(it);
  endtask

  task automatic load_width(input int i, input logic [62:0] w);
    req_t it;
    it = rand_req(MODE_LOAD_WIDTH);
    {it.px, it.py, it.pz} = {5'(i), 5'(i), 5'(i)};
    {it.wx, it.wy, it.wz} = {w, w, w};
    send(it);
  endtask

  // stop offering, let every read come back, then give the block some slack
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    while (scoreboard.outstanding() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    scoreboard.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(input int sx, input int sy, input int szz, input int ax,
                           input logic [63:0] ts, input logic [63:0] hc);
    cfg_write(REG_SIZE_X, 64'(sx));
    cfg_write(REG_SIZE_Y, 64'(sy));
    cfg_write(REG_SIZE_Z, 64'(szz));
    cfg_write(REG_ACTIVE_AXES, 64'(ax));
    cfg_write(REG_TIME_STEP, ts);
    cfg_write(REG_HM_COEF, hc);
    sz[0]    = scoreboard.eff(sx & 63);
    sz[1]    = scoreboard.eff(sy & 63);
    sz[2]    = scoreboard.eff(szz & 63);
    axes_eff = ((ax & 3) <= 1) ? 1 : (ax & 3);
  endtask

  // random traffic: mostly reads (with their fill loads), fresh loads and noise;
  // count is the number of requests sent, fill loads included
  task automatic random_traffic(input int count, input bit squeeze);
    int   first;
    int   r;
    bit   held;
    req_t it;
    first = sent_items;
    held  = 1'b0;
    while (sent_items - first < count) begin
      if (squeeze && !held && (sent_items - first >= 40)) begin
        hold_rsp = 1'b1;
        held     = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        issue_read(pick_pos(0), pick_pos(1), pick_pos(2));
      end else if (r < 70) begin
        it = rand_req(MODE_LOAD_CELL);
        {it.px, it.py, it.pz} = {5'(pick_pos(0)), 5'(pick_pos(1)), 5'(pick_pos(2))};
        send(it);
      end else if (r < 85) begin
        it = rand_req(MODE_LOAD_WIDTH);
        {it.px, it.py, it.pz} = {5'(pick_pos(0)), 5'(pick_pos(1)), 5'(pick_pos(2))};
        send(it);
      end else if (r < 93) begin
        // unused mode, dropped by the block
        send(rand_req(MODE_UNUSED));
      end else begin
        send(rand_req(MODE_LOAD_CELL));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // response side: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready)
        scoreboard.check_response(rsp_ch.new_density, rsp_ch.saturated);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake anywhere ends the run
  // --------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable && pready))
        idle = 0;
      else
        idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    calm     = 1'b0;
    hold_rsp = 1'b0;
    sent_items = 0;
    req_ch.valid    <= 1'b0;
    req_ch.mode     <= MODE_LOAD_CELL;
    req_ch.pos_x    <= '0;
    req_ch.pos_y    <= '0;
    req_ch.pos_z    <= '0;
    req_ch.density  <= '0;
    req_ch.psi_real <= '0;
    req_ch.psi_imag <= '0;
    req_ch.width_x  <= '0;
    req_ch.width_y  <= '0;
    req_ch.width_z  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // small grid, unit step and coefficient for the directed requests
    configure(4, 3, 2, 3, Q_ONE, Q_ONE);
    load_width(0, 63'(Q_ONE));
    load_width(1, W_MAX);
    load_width(2, 63'(Q_ONE));
    load_width(3, '0);                    // zero width on the upper boundary cell
    load_cell(0, 0, 0, SMAX, SMAX, SMIN);  // extremes next to each other
    load_cell(1, 0, 0, SMIN, SMIN, SMAX);
    load_cell(0, 1, 0, '0, '0, '0);
    issue_read(0, 0, 0);                  // lower boundary on every axis
    issue_read(1, 1, 1);                  // both faces on x and y
    issue_read(3, 2, 1);                  // upper boundary on every axis
    issue_read(5, 5, 5);                  // beyond the sizes in use
    issue_read(31, 31, 31);               // top index on every axis
    send(rand_req(MODE_UNUSED));
    load_cell(31, 31, 31, rand_q(), rand_q(), rand_q());
    issue_read(31, 31, 31);
    quiesce();

    random_traffic(240, 1'b0);
    quiesce();

    // single-cell grid, x only, extreme step and coefficient
    configure(1, 1, 1, 1, SMAX, SMIN);
    calm = 1'b1;
    random_traffic(220, 1'b0);
    quiesce();
    calm = 1'b0;

    // full grid in two axes, with one long response hold-off
    configure(32, 32, 32, 2, 64'hFFFF_0000_0000_0000, 64'h0000_8000_0000_0000);
    random_traffic(260, 1'b1);
    quiesce();

    // size zero acts as one, oversize acts as the maximum, axes zero as x only
    configure(0, 63, 5, 0, {$urandom, $urandom}, {$urandom, $urandom});
    random_traffic(260, 1'b0);
    quiesce();

    configure(8, 8, 8, 3, SMIN, SMAX);
    calm = 1'b1;
    random_traffic(260, 1'b0);
    quiesce();
    calm = 1'b0;

    configure(6, 2, 32, 3, 64'h0000_0400_0000_0000, 64'h0000_0200_0000_0000);
    random_traffic(280, 1'b0);
    quiesce();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.errors == 0 && scoreboard.outstanding() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
